[rtl/pect_pkg.sv]
`default_nettype none
package pect_pkg;

   localparam logic [1:0] STATUS_TRIANGLE = 2'd0;
   localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
   localparam logic [1:0] STATUS_NO_EAR   = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   localparam int MIN_VERTS = 3;

   // sign of a cross product
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

endpackage
`default_nettype wire

[rtl/pect_cross.sv]
`default_nettype none
// (q - p) x (r - p), three-stage pipeline, sign only
module pect_cross import pect_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          go,
   input  wire signed [COORD_BITS-1:0]  p_x,
   input  wire signed [COORD_BITS-1:0]  p_y,
   input  wire signed [COORD_BITS-1:0]  q_x,
   input  wire signed [COORD_BITS-1:0]  q_y,
   input  wire signed [COORD_BITS-1:0]  r_x,
   input  wire signed [COORD_BITS-1:0]  r_y,
   output logic                         done,
   output sign_type                     result
);
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic [2:0]              vld_ff;
   logic signed [DW-1:0]    d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   logic signed [PW-1:0]    pr1_ff, pr2_ff;
   logic signed [PW:0]      diff;
   sign_type                sgn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], go};
      end
   end

   assign diff = $signed({pr1_ff[PW-1], pr1_ff}) - $signed({pr2_ff[PW-1], pr2_ff});

   always_ff @(posedge clock) begin
      d1x_ff <= $signed({q_x[COORD_BITS-1], q_x}) - $signed({p_x[COORD_BITS-1], p_x});
      d1y_ff <= $signed({q_y[COORD_BITS-1], q_y}) - $signed({p_y[COORD_BITS-1], p_y});
      d2x_ff <= $signed({r_x[COORD_BITS-1], r_x}) - $signed({p_x[COORD_BITS-1], p_x});
      d2y_ff <= $signed({r_y[COORD_BITS-1], r_y}) - $signed({p_y[COORD_BITS-1], p_y});
      pr1_ff <= d1x_ff * d2y_ff;
      pr2_ff <= d1y_ff * d2x_ff;
      sgn_ff.neg  <= diff[PW];
      sgn_ff.zero <= (diff == '0);
   end

   assign done   = vld_ff[2];
   assign result = sgn_ff;

endmodule
`default_nettype wire

[rtl/polygon_ear_clip_triangulator.sv]
`default_nettype none
// Ear-clipping polygon triangulator.
// Input: one vertex word per accepted cycle (start high while busy low), carrying
//   signed x/y and a last marker. Vertices beyond MAX_VERTS are dropped and flag
//   an overflow. The word with last_vertex set closes the polygon; busy then stays
//   high until every result word has gone out.
// Output: rsp_valid marks a result word for exactly one cycle; the receiver
//   cannot stall. A polygon of n vertices gives n-2 triangle words in clipping
//   order, the last with rsp_final_result set, or one error word (status 1 too
//   few vertices, 2 no ear, 3 overflow) with all corners zero.
// Timing: triangulation walks the vertex memory (single port) and the order and
//   triangle memories (separate read and write addresses), all with registered
//   reads, and one shared cross-product pipeline that takes a new launch only
//   after the previous result is back. Each ear candidate and each tested vertex
//   uses it, a vertex for an edge test per ear side; skipped positions do not.
//   Clipping shifts the order memory one entry at a time; emitting reads each
//   triangle entry and its corners. The ear search loop sets the throughput.
// Reset: synchronous; clears the sequencer, vertex count and overflow flag.
//   Memories keep no reset and need no clearing pass.
module polygon_ear_clip_triangulator import pect_pkg::*; #(
   parameter int MAX_VERTS  = 64,
   parameter int COORD_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire signed [COORD_BITS-1:0]  req_vertex_x,
   input  wire signed [COORD_BITS-1:0]  req_vertex_y,
   input  wire                          req_last_vertex,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic signed [COORD_BITS-1:0] rsp_corner_a_x,
   output logic signed [COORD_BITS-1:0] rsp_corner_a_y,
   output logic signed [COORD_BITS-1:0] rsp_corner_b_x,
   output logic signed [COORD_BITS-1:0] rsp_corner_b_y,
   output logic signed [COORD_BITS-1:0] rsp_corner_c_x,
   output logic signed [COORD_BITS-1:0] rsp_corner_c_y,
   output logic                         rsp_final_result
);
   localparam int IW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam int TD = MAX_VERTS - 2;
   localparam int PW = 2 * COORD_BITS;
   localparam int CB = COORD_BITS;

   typedef enum logic [25:0] {
      S_IDLE  = 26'd1 << 0,
      S_CHECK = 26'd1 << 1,
      S_INIT  = 26'd1 << 2,
      S_EO0   = 26'd1 << 3,
      S_EO1   = 26'd1 << 4,
      S_EO2   = 26'd1 << 5,
      S_EC0   = 26'd1 << 6,
      S_EC1   = 26'd1 << 7,
      S_EC2   = 26'd1 << 8,
      S_EC3   = 26'd1 << 9,
      S_XRUN  = 26'd1 << 10,
      S_XWAIT = 26'd1 << 11,
      S_JCHK  = 26'd1 << 12,
      S_JO    = 26'd1 << 13,
      S_JC    = 26'd1 << 14,
      S_SAVE  = 26'd1 << 15,
      S_SHCHK = 26'd1 << 16,
      S_SHW   = 26'd1 << 17,
      S_MT    = 26'd1 << 18,
      S_MR    = 26'd1 << 19,
      S_MA    = 26'd1 << 20,
      S_MB    = 26'd1 << 21,
      S_MC    = 26'd1 << 22,
      S_MOUT  = 26'd1 << 23,
      S_ERR   = 26'd1 << 24,
      S_SPARE = 26'd1 << 25
   } state_type;

   // phases of the shared cross unit
   localparam logic [1:0] PH_EAR = 2'd0;
   localparam logic [1:0] PH_AB  = 2'd1;
   localparam logic [1:0] PH_BC  = 2'd2;
   localparam logic [1:0] PH_CA  = 2'd3;

   state_type state_ff, state_in;

   // memories
   logic [PW-1:0]   crd_mem [MAX_VERTS];
   logic [IW-1:0]   ord_mem [MAX_VERTS];
   logic [3*IW-1:0] tri_mem [TD];

   logic [PW-1:0]   crd_q_ff;
   logic [IW-1:0]   ord_q_ff;
   logic [3*IW-1:0] tri_q_ff;
   logic [IW-1:0]   crd_addr, ord_raddr, ord_waddr, ord_wdata;
   logic            crd_we, ord_we, tri_we;

   // control
   logic [CW-1:0] cnt_ff, m_ff, i_ff, j_ff, t_ff, k_ff;
   logic          ovf_ff;
   logic [IW-1:0] a_ff, b_ff, c_ff;
   logic [1:0]    phase_ff, status_ff;
   sign_type      s0_ff;

   logic signed [CB-1:0] pa_x_ff, pa_y_ff, pb_x_ff, pb_y_ff, pc_x_ff, pc_y_ff;
   logic signed [CB-1:0] pt_x_ff, pt_y_ff;

   logic [CW-1:0] i_nx, i1, i1_nx, i2, j_nx, k_nx;
   logic          accept, x_go, x_done, skip_j, last_tri;
   sign_type      x_sgn;
   logic signed [CB-1:0] op_p_x, op_p_y, op_q_x, op_q_y, op_r_x, op_r_y;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // ear positions modulo the remaining count
   assign i_nx  = i_ff + 1'b1;
   assign i1    = (i_nx == m_ff) ? '0 : i_nx;
   assign i1_nx = i1 + 1'b1;
   assign i2    = (i1_nx == m_ff) ? '0 : i1_nx;
   assign j_nx  = j_ff + 1'b1;
   assign k_nx  = k_ff + 1'b1;
   assign skip_j   = (j_ff == i_ff) || (j_ff == i1) || (j_ff == i2);
   assign last_tri = (k_nx == t_ff);

   // memory port control
   always_comb begin
      crd_addr = '0;
      case (state_ff)
         S_IDLE: crd_addr = cnt_ff[IW-1:0];
         S_EC0:  crd_addr = a_ff;
         S_EC1:  crd_addr = b_ff;
         S_EC2:  crd_addr = c_ff;
         S_JO:   crd_addr = ord_q_ff;
         S_MR:   crd_addr = tri_q_ff[3*IW-1:2*IW];
         S_MA:   crd_addr = tri_q_ff[2*IW-1:IW];
         S_MB:   crd_addr = tri_q_ff[IW-1:0];
         default: crd_addr = '0;
      endcase
   end

   always_comb begin
      ord_raddr = '0;
      case (state_ff)
         S_EO0:   ord_raddr = i_ff[IW-1:0];
         S_EO1:   ord_raddr = i1[IW-1:0];
         S_EO2:   ord_raddr = i2[IW-1:0];
         S_JCHK:  ord_raddr = j_ff[IW-1:0];
         S_SHCHK: ord_raddr = j_nx[IW-1:0];
         default: ord_raddr = '0;
      endcase
   end

   assign crd_we    = accept && (cnt_ff < CW'(MAX_VERTS));
   assign ord_we    = (state_ff == S_INIT) || (state_ff == S_SHW);
   assign ord_waddr = j_ff[IW-1:0];
   assign ord_wdata = (state_ff == S_INIT) ? j_ff[IW-1:0] : ord_q_ff;
   assign tri_we    = (state_ff == S_SAVE) ||
                      ((state_ff == S_EC0) && (m_ff == CW'(MIN_VERTS)));

   always_ff @(posedge clock) begin
      if (crd_we) begin
         crd_mem[crd_addr] <= {req_vertex_x, req_vertex_y};
      end
      crd_q_ff <= crd_mem[crd_addr];
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      ord_q_ff <= ord_mem[ord_raddr];
   end

   always_ff @(posedge clock) begin
      if (tri_we) begin
         tri_mem[t_ff[IW-1:0]] <= (state_ff == S_SAVE) ? {a_ff, b_ff, c_ff}
                                                       : {a_ff, b_ff, ord_q_ff};
      end
      tri_q_ff <= tri_mem[k_ff[IW-1:0]];
   end

   // shared cross-product unit
   always_comb begin
      op_p_x = pa_x_ff; op_p_y = pa_y_ff;
      op_q_x = pb_x_ff; op_q_y = pb_y_ff;
      op_r_x = pc_x_ff; op_r_y = pc_y_ff;
      case (phase_ff)
         PH_EAR: begin
            op_r_x = pc_x_ff; op_r_y = pc_y_ff;
         end
         PH_AB: begin
            op_r_x = pt_x_ff; op_r_y = pt_y_ff;
         end
         PH_BC: begin
            op_p_x = pb_x_ff; op_p_y = pb_y_ff;
            op_q_x = pc_x_ff; op_q_y = pc_y_ff;
            op_r_x = pt_x_ff; op_r_y = pt_y_ff;
         end
         PH_CA: begin
            op_p_x = pc_x_ff; op_p_y = pc_y_ff;
            op_q_x = pa_x_ff; op_q_y = pa_y_ff;
            op_r_x = pt_x_ff; op_r_y = pt_y_ff;
         end
         default: begin
            op_r_x = pc_x_ff; op_r_y = pc_y_ff;
         end
      endcase
   end

   assign x_go = (state_ff == S_XRUN);

   pect_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock  (clock),
      .reset  (reset),
      .go     (x_go),
      .p_x    (op_p_x),
      .p_y    (op_p_y),
      .q_x    (op_q_x),
      .q_y    (op_q_y),
      .r_x    (op_r_x),
      .r_y    (op_r_y),
      .done   (x_done),
      .result (x_sgn)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept && req_last_vertex) state_in = S_CHECK;
         S_CHECK: begin
            if (ovf_ff || (cnt_ff < CW'(MIN_VERTS))) state_in = S_ERR;
            else                                     state_in = S_INIT;
         end
         S_INIT:  if (j_nx == m_ff) state_in = S_EO0;
         S_EO0:   state_in = S_EO1;
         S_EO1:   state_in = S_EO2;
         S_EO2:   state_in = S_EC0;
         S_EC0: begin
            if (m_ff == CW'(MIN_VERTS)) state_in = S_MT;
            else                        state_in = S_EC1;
         end
         S_EC1:   state_in = S_EC2;
         S_EC2:   state_in = S_EC3;
         S_EC3:   state_in = S_XRUN;
         S_XRUN:  state_in = S_XWAIT;
         S_XWAIT: begin
            if (x_done) begin
               if (phase_ff == PH_EAR) begin
                  if (!x_sgn.neg)           state_in = S_JCHK;
                  else if (i_nx == m_ff)    state_in = S_ERR;
                  else                      state_in = S_EO0;
               end else if (x_sgn != s0_ff) begin
                  state_in = S_JCHK;
               end else if (phase_ff == PH_CA) begin
                  // a remaining vertex lies inside: not an ear
                  if (i_nx == m_ff) state_in = S_ERR;
                  else              state_in = S_EO0;
               end else begin
                  state_in = S_XRUN;
               end
            end
         end
         S_JCHK: begin
            if (j_ff == m_ff)  state_in = S_SAVE;
            else if (!skip_j)  state_in = S_JO;
         end
         S_JO:    state_in = S_JC;
         S_JC:    state_in = S_XRUN;
         S_SAVE:  state_in = S_SHCHK;
         S_SHCHK: begin
            if (j_nx >= m_ff) state_in = S_EO0;
            else              state_in = S_SHW;
         end
         S_SHW:   state_in = S_SHCHK;
         S_MT:    state_in = S_MR;
         S_MR:    state_in = S_MA;
         S_MA:    state_in = S_MB;
         S_MB:    state_in = S_MC;
         S_MC:    state_in = S_MOUT;
         S_MOUT: begin
            if (last_tri) state_in = S_IDLE;
            else          state_in = S_MT;
         end
         S_ERR:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            if (cnt_ff < CW'(MAX_VERTS)) cnt_ff <= cnt_ff + 1'b1;
            else                         ovf_ff <= 1'b1;
         end
         if (state_ff == S_CHECK) begin
            cnt_ff <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   // datapath and loop counters
   always_ff @(posedge clock) begin
      case (state_ff)
         S_CHECK: begin
            m_ff <= cnt_ff;
            t_ff <= '0;
            j_ff <= '0;
            i_ff <= '0;
            {pa_x_ff, pa_y_ff, pb_x_ff, pb_y_ff, pc_x_ff, pc_y_ff} <= '0;
            if (ovf_ff)                          status_ff <= STATUS_OVERFLOW;
            else if (cnt_ff < CW'(MIN_VERTS))    status_ff <= STATUS_TOO_FEW;
            else                                 status_ff <= STATUS_TRIANGLE;
         end
         S_INIT:  j_ff <= j_nx;
         S_EO1:   a_ff <= ord_q_ff;
         S_EO2:   b_ff <= ord_q_ff;
         S_EC0: begin
            c_ff <= ord_q_ff;
            if (m_ff == CW'(MIN_VERTS)) begin
               t_ff <= t_ff + 1'b1;
               k_ff <= '0;
            end
         end
         S_EC1: begin
            pa_x_ff <= crd_q_ff[PW-1:CB];
            pa_y_ff <= crd_q_ff[CB-1:0];
         end
         S_EC2: begin
            pb_x_ff <= crd_q_ff[PW-1:CB];
            pb_y_ff <= crd_q_ff[CB-1:0];
         end
         S_EC3: begin
            pc_x_ff  <= crd_q_ff[PW-1:CB];
            pc_y_ff  <= crd_q_ff[CB-1:0];
            phase_ff <= PH_EAR;
         end
         S_XWAIT: begin
            if (x_done) begin
               if (phase_ff == PH_EAR) begin
                  if (!x_sgn.neg) begin
                     s0_ff <= x_sgn;
                     j_ff  <= '0;
                  end else if (i_nx == m_ff) begin
                     status_ff <= STATUS_NO_EAR;
                     {pa_x_ff, pa_y_ff, pb_x_ff, pb_y_ff, pc_x_ff, pc_y_ff} <= '0;
                  end else begin
                     i_ff <= i_nx;
                  end
               end else if (x_sgn != s0_ff) begin
                  j_ff <= j_nx;
               end else if (phase_ff == PH_CA) begin
                  if (i_nx == m_ff) begin
                     status_ff <= STATUS_NO_EAR;
                     {pa_x_ff, pa_y_ff, pb_x_ff, pb_y_ff, pc_x_ff, pc_y_ff} <= '0;
                  end else begin
                     i_ff <= i_nx;
                  end
               end else begin
                  phase_ff <= phase_ff + 1'b1;
               end
            end
         end
         S_JCHK:  if ((j_ff != m_ff) && skip_j) j_ff <= j_nx;
         S_JC: begin
            pt_x_ff  <= crd_q_ff[PW-1:CB];
            pt_y_ff  <= crd_q_ff[CB-1:0];
            phase_ff <= PH_AB;
         end
         S_SAVE: begin
            t_ff <= t_ff + 1'b1;
            j_ff <= i1;
         end
         S_SHCHK: begin
            if (j_nx >= m_ff) begin
               m_ff <= m_ff - 1'b1;
               i_ff <= '0;
            end
         end
         S_SHW:   j_ff <= j_nx;
         S_MA: begin
            pa_x_ff <= crd_q_ff[PW-1:CB];
            pa_y_ff <= crd_q_ff[CB-1:0];
         end
         S_MB: begin
            pb_x_ff <= crd_q_ff[PW-1:CB];
            pb_y_ff <= crd_q_ff[CB-1:0];
         end
         S_MC: begin
            pc_x_ff <= crd_q_ff[PW-1:CB];
            pc_y_ff <= crd_q_ff[CB-1:0];
         end
         S_MOUT:  k_ff <= k_nx;
         default: ;
      endcase
   end

   assign rsp_valid        = (state_ff == S_MOUT) || (state_ff == S_ERR);
   assign rsp_final_result = (state_ff == S_ERR) || ((state_ff == S_MOUT) && last_tri);
   assign rsp_status       = status_ff;
   assign rsp_corner_a_x   = pa_x_ff;
   assign rsp_corner_a_y   = pa_y_ff;
   assign rsp_corner_b_x   = pb_x_ff;
   assign rsp_corner_b_y   = pb_y_ff;
   assign rsp_corner_c_x   = pc_x_ff;
   assign rsp_corner_c_y   = pc_y_ff;

endmodule
`default_nettype wire

[rtl/pect_checker.sv]
`default_nettype none
module pect_checker import pect_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input wire                  clock,
   input wire                  reset,
   input wire                  busy,
   input wire                  rsp_valid,
   input wire [1:0]            rsp_status,
   input wire [COORD_BITS-1:0] rsp_corner_a_x,
   input wire [COORD_BITS-1:0] rsp_corner_c_y,
   input wire                  rsp_final_result
);
   // results only come out while a polygon is in work
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result word while idle");

   // the final word frees the block
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_result |=> !busy) else $error("busy after final word");

   // an error word is always alone
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_TRIANGLE) |-> rsp_final_result)
      else $error("error word not final");

   // error words carry zero corners
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_TRIANGLE) |->
      (rsp_corner_a_x == '0) && (rsp_corner_c_y == '0))
      else $error("error word with corners");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid) else $error("not idle after reset");

endmodule

bind polygon_ear_clip_triangulator pect_checker #(.COORD_BITS(COORD_BITS)) u_pect_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_corner_a_x   (rsp_corner_a_x),
   .rsp_corner_c_y   (rsp_corner_c_y),
   .rsp_final_result (rsp_final_result)
);
`default_nettype wire

[sim/polygon_ear_clip_triangulator_test.sv]
`default_nettype none
module polygon_ear_clip_triangulator_test;
   import pect_pkg::*;

   localparam int MAX_VERTS  = 64;
   localparam int WATCHDOG   = 4000000;   // idle cycles allowed
   localparam int DRAIN_WAIT = 200;

   // one vertex word for the driver; hold_off makes the sender wait for a drained pipe
   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
      logic               hold_off;
   } vertex_word_type;

   // one triangle (or error) word as it should appear on rsp_*
   typedef struct {
      logic [1:0]         status;
      logic signed [15:0] ax, ay, bx, by, cx, cy;
      logic               fin;
   } tri_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_vertex_x = '0;
   logic signed [15:0] req_vertex_y = '0;
   logic req_last_vertex = 1'b0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic signed [15:0] rsp_corner_a_x, rsp_corner_a_y, rsp_corner_b_x;
   logic signed [15:0] rsp_corner_b_y, rsp_corner_c_x, rsp_corner_c_y;
   logic rsp_final_result;

   polygon_ear_clip_triangulator #(.MAX_VERTS(MAX_VERTS), .COORD_BITS(16)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_last_vertex(req_last_vertex),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_corner_a_x(rsp_corner_a_x), .rsp_corner_a_y(rsp_corner_a_y),
      .rsp_corner_b_x(rsp_corner_b_x), .rsp_corner_b_y(rsp_corner_b_y),
      .rsp_corner_c_x(rsp_corner_c_x), .rsp_corner_c_y(rsp_corner_c_y),
      .rsp_final_result(rsp_final_result)
   );

   always #6 clock = ~clock;

   vertex_word_type vertex_q[$];     // words still to send
   tri_word_type    triangle_q[$];   // triangles the block owes us
   vertex_word_type cur_word;        // word currently on req_*

   int  words_sent = 0;
   int  words_rcvd = 0;
   int  polygons_sent = 0;
   int  mismatches = 0;
   int  orphans = 0;
   int  idle_cycles = 0;

   // shadow copy of the vertex memory and load state
   int  shadow_x [MAX_VERTS];
   int  shadow_y [MAX_VERTS];
   int  shadow_count = 0;
   bit  shadow_overflow = 1'b0;

   // cross(b - a, c - a) on shadow indices
   function automatic longint edge_cross(int a, int b, int c);
      longint ux, uy, vx, vy;
      ux = shadow_x[b] - shadow_x[a];
      uy = shadow_y[b] - shadow_y[a];
      vx = shadow_x[c] - shadow_x[a];
      vy = shadow_y[c] - shadow_y[a];
      return ux * vy - uy * vx;
   endfunction

   function automatic int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // sign-match containment; boundary points of a non-degenerate ear count as outside
   function automatic bit point_in_ear(int t, int a, int b, int c);
      return sign_of(edge_cross(a, b, c)) == sign_of(edge_cross(a, b, t)) &&
             sign_of(edge_cross(b, c, a)) == sign_of(edge_cross(b, c, t)) &&
             sign_of(edge_cross(c, a, b)) == sign_of(edge_cross(c, a, t));
   endfunction

   function automatic tri_word_type make_triangle(int a, int b, int c, bit fin);
      tri_word_type w;
      w.status = STATUS_TRIANGLE;
      w.ax = shadow_x[a]; w.ay = shadow_y[a];
      w.bx = shadow_x[b]; w.by = shadow_y[b];
      w.cx = shadow_x[c]; w.cy = shadow_y[c];
      w.fin = fin;
      return w;
   endfunction

   function automatic tri_word_type make_error(logic [1:0] st);
      tri_word_type w;
      w = '{st, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1};
      return w;
   endfunction

   // clip ears over the shadow polygon and queue the expected words
   task automatic clip_polygon();
      int order [MAX_VERTS];
      int tri_a [MAX_VERTS], tri_b [MAX_VERTS], tri_c [MAX_VERTS];
      int m, n_tri, ear, i, j, i1, i2;
      bit found, clear;
      m = shadow_count;
      n_tri = 0;
      for (i = 0; i < m; i++) order[i] = i;
      while (m > 3) begin
         found = 1'b0;
         ear = 0;
         for (i = 0; i < m && !found; i++) begin
            i1 = (i + 1) % m;
            i2 = (i + 2) % m;
            if (edge_cross(order[i], order[i1], order[i2]) < 0) continue;
            clear = 1'b1;
            for (j = 0; j < m && clear; j++) begin
               // only the ear's own three corners are excluded, with wrap
               if (j == i || j == i1 || j == i2) continue;
               if (point_in_ear(order[j], order[i], order[i1], order[i2])) clear = 1'b0;
            end
            if (clear) begin
               found = 1'b1;
               ear = i;
            end
         end
         if (!found) begin
            // no ear: earlier clipped triangles are dropped
            triangle_q.push_back(make_error(STATUS_NO_EAR));
            return;
         end
         tri_a[n_tri] = order[ear];
         tri_b[n_tri] = order[(ear + 1) % m];
         tri_c[n_tri] = order[(ear + 2) % m];
         n_tri++;
         for (j = (ear + 1) % m; j + 1 < m; j++) order[j] = order[j + 1];
         m--;
      end
      tri_a[n_tri] = order[0];
      tri_b[n_tri] = order[1];
      tri_c[n_tri] = order[2];
      n_tri++;
      for (i = 0; i < n_tri; i++)
         triangle_q.push_back(make_triangle(tri_a[i], tri_b[i], tri_c[i], i + 1 == n_tri));
   endtask

   // one accepted vertex word
   task automatic load_vertex(vertex_word_type w);
      if (shadow_count < MAX_VERTS) begin
         shadow_x[shadow_count] = w.x;
         shadow_y[shadow_count] = w.y;
         shadow_count++;
      end else begin
         shadow_overflow = 1'b1;
      end
      if (!w.last) return;
      if (shadow_overflow)
         triangle_q.push_back(make_error(STATUS_OVERFLOW));
      else if (shadow_count < MIN_VERTS)
         triangle_q.push_back(make_error(STATUS_TOO_FEW));
      else
         clip_polygon();
      shadow_count = 0;
      shadow_overflow = 1'b0;
      polygons_sent++;
   endtask

   // sender idle rate follows the test phase
   function automatic bit sender_idles();
      if (words_sent < 90)  return $urandom_range(99) < 16;
      if (words_sent < 180) return $urandom_range(99) < 58;
      return 1'b0;
   endfunction

   // driver: hold a word until start && !busy, then load the next one
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            load_vertex(cur_word);
            words_sent++;
         end
         if (vertex_q.size() > 0 && !sender_idles() &&
             !(vertex_q[0].hold_off && (triangle_q.size() > 0 || busy))) begin
            cur_word = vertex_q.pop_front();
            req_vertex_x    <= cur_word.x;
            req_vertex_y    <= cur_word.y;
            req_last_vertex <= cur_word.last;
            start           <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed word against the oldest expectation
   always @(posedge clock) begin
      tri_word_type want;
      if (!reset && rsp_valid) begin
         words_rcvd++;
         if (triangle_q.size() == 0) begin
            orphans++;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: status %0d a(%0d,%0d)", rsp_status,
                        rsp_corner_a_x, rsp_corner_a_y);
         end else begin
            want = triangle_q.pop_front();
            if (rsp_status !== want.status || rsp_final_result !== want.fin ||
                rsp_corner_a_x !== want.ax || rsp_corner_a_y !== want.ay ||
                rsp_corner_b_x !== want.bx || rsp_corner_b_y !== want.by ||
                rsp_corner_c_x !== want.cx || rsp_corner_c_y !== want.cy) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp: st %0d a(%0d,%0d) b(%0d,%0d) c(%0d,%0d) fin %0d",
                           want.status, want.ax, want.ay, want.bx, want.by,
                           want.cx, want.cy, want.fin);
                  $display("         got: st %0d a(%0d,%0d) b(%0d,%0d) c(%0d,%0d) fin %0d",
                           rsp_status, rsp_corner_a_x, rsp_corner_a_y, rsp_corner_b_x,
                           rsp_corner_b_y, rsp_corner_c_x, rsp_corner_c_y,
                           rsp_final_result);
               end
            end
         end
      end
   end

   // watchdog: cycles with neither a vertex nor a result word accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired, %0d words still owed", triangle_q.size());
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------- stimulus helpers --------
   function automatic int clamp16(int v);
      return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
   endfunction

   task automatic add_vertex(int x, int y, bit last, bit hold = 1'b0);
      vertex_word_type w;
      w.x = clamp16(x);
      w.y = clamp16(y);
      w.last = last;
      w.hold_off = hold;
      vertex_q.push_back(w);
   endtask

   // shape kinds for the random part
   typedef enum int {
      SHAPE_CONVEX, SHAPE_STAR, SHAPE_SCATTER, SHAPE_CLOCKWISE, SHAPE_LINE, SHAPE_TINY
   } shape_kind_type;

   // ring of n points; jagged alternates the radius (concave star), cw reverses
   task automatic add_ring(int n, bit jagged, bit cw, bit hold);
      real ang, rad;
      int  cx, cy, r, k;
      cx = $urandom_range(20000) - 10000;
      cy = $urandom_range(20000) - 10000;
      r  = $urandom_range(22000, 40);
      for (k = 0; k < n; k++) begin
         ang = 6.283185307 * k / n;
         if (cw) ang = -ang;
         rad = (jagged && k % 2) ? r * 0.4 : r;
         add_vertex(cx + $rtoi(rad * $cos(ang)), cy + $rtoi(rad * $sin(ang)),
                    k == n - 1, hold && k == 0);
      end
   endtask

   task automatic add_random_shape(bit hold);
      shape_kind_type kind;
      int n, k, x0, y0, dx, dy;
      kind = shape_kind_type'($urandom_range(5));
      n = $urandom_range(9, 3);
      case (kind)
         SHAPE_CONVEX:    add_ring(n, 1'b0, 1'b0, hold);
         SHAPE_STAR:      add_ring((n < 6) ? 6 : n, 1'b1, 1'b0, hold);
         SHAPE_CLOCKWISE: add_ring(n, 1'b0, 1'b1, hold);
         SHAPE_SCATTER: begin
            for (k = 0; k < n; k++)
               add_vertex($signed($urandom_range(65535)) - 32768,
                          $signed($urandom_range(65535)) - 32768, k == n - 1, hold && k == 0);
         end
         SHAPE_LINE: begin
            x0 = $urandom_range(2000) - 1000;
            y0 = $urandom_range(2000) - 1000;
            dx = $urandom_range(300) - 150;
            dy = $urandom_range(300) - 150;
            for (k = 0; k < n; k++)
               add_vertex(x0 + k * dx, y0 + k * dy, k == n - 1, hold && k == 0);
         end
         default: begin
            n = $urandom_range(2, 1);
            for (k = 0; k < n; k++)
               add_vertex($signed($urandom_range(65535)) - 32768,
                          $signed($urandom_range(65535)) - 32768, k == n - 1, hold && k == 0);
         end
      endcase
   endtask

   initial begin
      int k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: too few (1 and 2 vertices)
      add_vertex(-32768, 32767, 1'b1);
      add_vertex(32767, -32768, 1'b0);
      add_vertex(0, 0, 1'b1);
      // single triangle at the coordinate extremes
      add_vertex(-32768, -32768, 1'b0);
      add_vertex(32767, -32768, 1'b0);
      add_vertex(-32768, 32767, 1'b1);
      // full-range square, counterclockwise
      add_vertex(-32768, -32768, 1'b0);
      add_vertex(32767, -32768, 1'b0);
      add_vertex(32767, 32767, 1'b0);
      add_vertex(-32768, 32767, 1'b1);
      // clockwise square: no ear anywhere
      add_vertex(0, 0, 1'b0);
      add_vertex(0, 100, 1'b0);
      add_vertex(100, 100, 1'b0);
      add_vertex(100, 0, 1'b1);
      // collinear four: zero cross passes, containment by sign match
      add_vertex(0, 0, 1'b0);
      add_vertex(1, 1, 1'b0);
      add_vertex(2, 2, 1'b0);
      add_vertex(3, 3, 1'b1);
      // concave arrow: first candidate rejected, the second candidate is the ear
      add_vertex(0, 0, 1'b0);
      add_vertex(10, 5, 1'b0);
      add_vertex(0, 10, 1'b0);
      add_vertex(3, 5, 1'b1);
      // overflow: 66 vertices, last two dropped
      for (k = 0; k < MAX_VERTS + 2; k++)
         add_vertex($urandom_range(1000), $urandom_range(1000), k == MAX_VERTS + 1);
      // largest legal polygon, convex; sender waits for a drained block first
      add_ring(MAX_VERTS, 1'b0, 1'b0, 1'b1);

      // random polygons, mostly small; an occasional drained pause
      while (vertex_q.size() < 230)
         add_random_shape($urandom_range(19) == 0);

      wait (vertex_q.size() == 0 && !start);
      wait (triangle_q.size() == 0 && !busy);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d vertex words in %0d polygons, checked %0d result words",
               words_sent, polygons_sent, words_rcvd);
      $display("errors: %0d mismatched or unexpected (%0d unexpected), %0d still owed",
               mismatches, orphans, triangle_q.size());
      if (mismatches == 0 && triangle_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
rtl/pect_pkg.sv
rtl/pect_cross.sv
rtl/polygon_ear_clip_triangulator.sv
rtl/pect_checker.sv
sim/polygon_ear_clip_triangulator_test.sv
